[design/sev_pkg.sv]
// ----------------------------------------------------------------------------
// sev_pkg: shared types and constants of the shake envelope oscillator
// Register indexes, fixed-point constants, the configuration and result
// records passed between the top level and the arithmetic core.
// ----------------------------------------------------------------------------
package sev_pkg;

    localparam int EASE_STEPS_DEF = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BEZIER     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PHASES     = 3'd7;

    // Item operations
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Stream payload widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 88;

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [8:0]  WEIGHT_ONE = 9'd256;
    localparam logic [16:0] APPLY_MIN  = 17'd6;
    localparam logic [16:0] END_MAX    = 17'd65;
    localparam logic [15:0] FREQ_MIN   = 16'd3;
    localparam logic [16:0] SIN_A      = 17'd102944;
    localparam logic [16:0] SIN_B      = 17'd42048;
    localparam logic [16:0] SIN_C      = 17'd4640;

    // Oscillator frequency ratios 1.00, 1.18, 1.37, 0.77 in Q16
    localparam logic [3:0][16:0] OSC_MULT = {17'd50463, 17'd89784, 17'd77332, 17'd65536};

    // Serial multiplier and divider widths
    localparam int MUL_W  = 64;
    localparam int MUL_BW = 32;
    localparam int MUL_CW = 6;
    localparam int DIV_W  = 32;
    localparam int QUO_STEPS = 16;

    typedef struct packed {
        logic [31:0]      duration;
        logic [15:0]      blend_in;
        logic [15:0]      blend_out;
        logic [15:0]      frequency;
        logic [15:0]      amp_loc;
        logic [15:0]      amp_rot;
        logic [8:0]       weight;
        logic             curve_mode;
        logic [15:0]      p1x;
        logic [15:0]      p1y;
        logic [15:0]      p2x;
        logic [15:0]      p2y;
        logic [3:0][15:0] phase;
    } cfg_t;

    typedef struct packed {
        logic        active;
        logic [16:0] offset_x;
        logic [16:0] offset_y;
        logic [16:0] offset_z;
        logic [16:0] rotation_offset;
        logic [16:0] envelope;
        logic        running;
    } res_t;

endpackage

[design/sev_mul.sv]
// ----------------------------------------------------------------------------
// sev_mul: bit-serial shift-add multiplier
// Retires one multiplier bit per cycle; the product is truncated to MUL_W.
// ----------------------------------------------------------------------------
module sev_mul
    import sev_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_BW-1:0] b,
    input  logic [MUL_CW-1:0] nbits,
    output logic              done,
    output logic [MUL_W-1:0]  p
);

    logic              busy_reg;
    logic              done_reg;
    logic [MUL_CW-1:0] cnt_reg;
    logic [MUL_W-1:0]  acc_reg;
    logic [MUL_W-1:0]  a_reg;
    logic [MUL_BW-1:0] b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - MUL_CW'(1);
                if (cnt_reg == MUL_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[MUL_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MUL_BW-1:1]};
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

[design/sev_div.sv]
// ----------------------------------------------------------------------------
// sev_div: bit-serial fraction divider
// Gives min(floor(n * 2^16 / d), 1.0) with one restoring step per cycle.
// ----------------------------------------------------------------------------
module sev_div
    import sev_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [DIV_W-1:0] n,
    input  logic [DIV_W-1:0] d,
    output logic             done,
    output logic [16:0]      q
);

    localparam int CNT_W = $clog2(QUO_STEPS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [16:0]      q_reg;
    logic             sat;
    logic [DIV_W:0]   rem_dbl;
    logic             ge;
    logic [DIV_W:0]   rem_sub;

    // A quotient of one or more saturates; a zero divisor lands here too.
    assign sat     = (n >= d);
    assign rem_dbl = {rem_reg, 1'b0};
    assign ge      = (rem_dbl >= {1'b0, d});
    assign rem_sub = rem_dbl - {1'b0, d};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                if (sat)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(QUO_STEPS);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= n;
            q_reg   <= sat ? ONE_Q16 : 17'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DIV_W-1:0] : rem_dbl[DIV_W-1:0];
            q_reg   <= {q_reg[15:0], ge};
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

[design/sev_core.sv]
// ----------------------------------------------------------------------------
// sev_core: envelope and oscillator sequencer
// Walks one item through the envelope, easing curve and four sine
// oscillators, sharing one serial multiplier and one serial divider.
// ----------------------------------------------------------------------------
module sev_core
    import sev_pkg::*;
#(
    parameter int EASE_STEPS = EASE_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        start,
    input  logic        op,
    input  logic [15:0] delta_time,
    output logic        idle,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    localparam int STEP_W = $clog2(EASE_STEPS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_ADD, S_DIVX, S_DIVIN, S_DIVOUT, S_SHAPE, S_SM1, S_SM2,
        S_BMID, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9, S_BCMP,
        S_WGT, S_O1, S_O2, S_O3, S_O4, S_O5, S_O6, S_O7, S_O8, S_END, S_DONE
    } state_t;

    state_t           state_reg;
    logic             wait_reg;
    logic [31:0]      elapsed_reg;
    logic [16:0]      level_reg;
    logic             enabled_reg;
    logic [15:0]      dt_reg;
    logic [16:0]      x_reg;
    logic [16:0]      ain_reg;
    logic [16:0]      a_reg;
    logic [16:0]      curve_reg;
    logic [16:0]      lo_reg;
    logic [16:0]      hi_reg;
    logic [16:0]      s_reg;
    logic [STEP_W-1:0] step_reg;
    logic             pass_y_reg;
    logic [32:0]      us_reg;
    logic [48:0]      tmp_reg;
    logic [32:0]      w1_reg;
    logic [32:0]      w2_reg;
    logic [32:0]      w3_reg;
    logic [48:0]      acc1_reg;
    logic [17:0]      val_reg;
    logic [1:0]       k_reg;
    logic [32:0]      fk_reg;
    logic [16:0]      xo_reg;
    logic             neg_reg;
    logic [16:0]      x2_reg;
    logic [16:0]      t_reg;
    logic [16:0]      mag_reg;
    logic [32:0]      ma_reg;
    logic             active_reg;
    logic [3:0][16:0] off_reg;

    logic              mul_go;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [MUL_CW-1:0] mul_n;
    logic              mul_done;
    logic [MUL_W-1:0]  mul_p;
    logic              div_go;
    logic [DIV_W-1:0]  div_n;
    logic [DIV_W-1:0]  div_d;
    logic              div_done;
    logic [16:0]       div_q;

    logic              uses_mul;
    logic              uses_div;
    logic [16:0]       u_w;
    logic [15:0]       fmin;
    logic [15:0]       p1_sel;
    logic [15:0]       p2_sel;
    logic [15:0]       amp_sel;
    logic [32:0]       elapsed_sum;
    logic [17:0]       mid_sum;
    logic [MUL_W-1:0]  bez_sum;
    logic [15:0]       ph;
    logic [14:0]       fold;
    logic [17:0]       sin_t;
    logic [16:0]       v_w;

    assign u_w         = ONE_Q16 - s_reg;
    assign fmin        = (cfg.frequency < FREQ_MIN) ? FREQ_MIN : cfg.frequency;
    assign p1_sel      = pass_y_reg ? cfg.p1y : cfg.p1x;
    assign p2_sel      = pass_y_reg ? cfg.p2y : cfg.p2x;
    assign amp_sel     = (k_reg == 2'd3) ? cfg.amp_rot : cfg.amp_loc;
    assign elapsed_sum = {1'b0, elapsed_reg} + {17'd0, dt_reg};
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign bez_sum     = {15'd0, acc1_reg} + mul_p + {15'd0, w3_reg, 16'd0};
    assign ph          = mul_p[39:24] + cfg.phase[k_reg];
    assign fold        = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    assign sin_t       = {1'b0, SIN_A} - mul_p[33:16];
    assign v_w         = mul_p[48:32];

    always_comb
    begin
        uses_mul = 1'b0;
        uses_div = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        mul_n    = '0;
        div_n    = '0;
        div_d    = '0;
        case (state_reg)
            S_DIVX:
            begin
                uses_div = 1'b1;
                div_n    = elapsed_reg;
                div_d    = cfg.duration;
            end
            S_DIVIN:
            begin
                uses_div = 1'b1;
                div_n    = DIV_W'(x_reg);
                div_d    = DIV_W'(cfg.blend_in);
            end
            S_DIVOUT:
            begin
                uses_div = 1'b1;
                div_n    = DIV_W'(ONE_Q16 - x_reg);
                div_d    = DIV_W'(cfg.blend_out);
            end
            S_SM1:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(a_reg);
                mul_b    = MUL_BW'(a_reg);
                mul_n    = MUL_CW'(17);
            end
            S_SM2:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(tmp_reg);
                mul_b    = MUL_BW'(18'd196608 - {a_reg, 1'b0});
                mul_n    = MUL_CW'(18);
            end
            S_C1:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(u_w);
                mul_b    = MUL_BW'(s_reg);
                mul_n    = MUL_CW'(17);
            end
            S_C2:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(us_reg);
                mul_b    = MUL_BW'(u_w);
                mul_n    = MUL_CW'(17);
            end
            S_C3, S_C5:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(tmp_reg);
                mul_b    = MUL_BW'(3);
                mul_n    = MUL_CW'(2);
            end
            S_C4:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(us_reg);
                mul_b    = MUL_BW'(s_reg);
                mul_n    = MUL_CW'(17);
            end
            S_C6:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(s_reg);
                mul_b    = MUL_BW'(s_reg);
                mul_n    = MUL_CW'(17);
            end
            S_C7:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(tmp_reg);
                mul_b    = MUL_BW'(s_reg);
                mul_n    = MUL_CW'(17);
            end
            S_C8:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(w1_reg);
                mul_b    = MUL_BW'(p1_sel);
                mul_n    = MUL_CW'(16);
            end
            S_C9:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(w2_reg);
                mul_b    = MUL_BW'(p2_sel);
                mul_n    = MUL_CW'(16);
            end
            S_WGT:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(curve_reg);
                mul_b    = MUL_BW'(cfg.weight);
                mul_n    = MUL_CW'(9);
            end
            S_O1:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(OSC_MULT[k_reg]);
                mul_b    = MUL_BW'(fmin);
                mul_n    = MUL_CW'(16);
            end
            S_O2:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(fk_reg);
                mul_b    = elapsed_reg;
                mul_n    = MUL_CW'(32);
            end
            S_O3:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(xo_reg);
                mul_b    = MUL_BW'(xo_reg);
                mul_n    = MUL_CW'(17);
            end
            S_O4:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(SIN_C);
                mul_b    = MUL_BW'(x2_reg);
                mul_n    = MUL_CW'(17);
            end
            S_O5:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(t_reg);
                mul_b    = MUL_BW'(x2_reg);
                mul_n    = MUL_CW'(17);
            end
            S_O6:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(xo_reg);
                mul_b    = MUL_BW'(t_reg);
                mul_n    = MUL_CW'(17);
            end
            S_O7:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(mag_reg);
                mul_b    = MUL_BW'(amp_sel);
                mul_n    = MUL_CW'(16);
            end
            S_O8:
            begin
                uses_mul = 1'b1;
                mul_a    = MUL_W'(ma_reg);
                mul_b    = MUL_BW'(level_reg);
                mul_n    = MUL_CW'(17);
            end
            default:
            begin
                uses_mul = 1'b0;
            end
        endcase
    end

    assign mul_go = uses_mul && !wait_reg;
    assign div_go = uses_div && !wait_reg;

    sev_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .nbits (mul_n),
        .done  (mul_done),
        .p     (mul_p)
    );

    sev_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .n     (div_n),
        .d     (div_d),
        .done  (div_done),
        .q     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wait_reg    <= 1'b0;
            elapsed_reg <= '0;
            level_reg   <= '0;
            enabled_reg <= 1'b1;
            dt_reg      <= '0;
            x_reg       <= '0;
            ain_reg     <= '0;
            a_reg       <= '0;
            curve_reg   <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            s_reg       <= '0;
            step_reg    <= '0;
            pass_y_reg  <= 1'b0;
            us_reg      <= '0;
            tmp_reg     <= '0;
            w1_reg      <= '0;
            w2_reg      <= '0;
            w3_reg      <= '0;
            acc1_reg    <= '0;
            val_reg     <= '0;
            k_reg       <= '0;
            fk_reg      <= '0;
            xo_reg      <= '0;
            neg_reg     <= 1'b0;
            x2_reg      <= '0;
            t_reg       <= '0;
            mag_reg     <= '0;
            ma_reg      <= '0;
            active_reg  <= 1'b0;
            off_reg     <= '0;
        end
        else
        begin
            if (mul_go || div_go)
            begin
                wait_reg <= 1'b1;
            end
            if (mul_done || div_done)
            begin
                wait_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        dt_reg     <= delta_time;
                        active_reg <= 1'b0;
                        off_reg    <= '0;
                        if (op == OP_START)
                        begin
                            elapsed_reg <= '0;
                            level_reg   <= '0;
                            enabled_reg <= 1'b1;
                            state_reg   <= S_DONE;
                        end
                        else if (enabled_reg && (cfg.weight != 9'd0))
                        begin
                            state_reg <= S_ADD;
                        end
                        else
                        begin
                            state_reg <= S_END;
                        end
                    end
                end
                S_ADD:
                begin
                    elapsed_reg <= elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
                    if (cfg.duration == 32'd0)
                    begin
                        curve_reg <= ONE_Q16;
                        state_reg <= S_WGT;
                    end
                    else
                    begin
                        state_reg <= S_DIVX;
                    end
                end
                S_DIVX:
                begin
                    if (div_done)
                    begin
                        x_reg     <= div_q;
                        state_reg <= S_DIVIN;
                    end
                end
                S_DIVIN:
                begin
                    if (div_done)
                    begin
                        ain_reg   <= div_q;
                        state_reg <= S_DIVOUT;
                    end
                end
                S_DIVOUT:
                begin
                    if (div_done)
                    begin
                        a_reg     <= (div_q < ain_reg) ? div_q : ain_reg;
                        state_reg <= S_SHAPE;
                    end
                end
                S_SHAPE:
                begin
                    if (cfg.curve_mode)
                    begin
                        lo_reg     <= '0;
                        hi_reg     <= ONE_Q16;
                        step_reg   <= '0;
                        pass_y_reg <= 1'b0;
                        state_reg  <= S_BMID;
                    end
                    else
                    begin
                        state_reg <= S_SM1;
                    end
                end
                S_SM1:
                begin
                    if (mul_done)
                    begin
                        tmp_reg   <= mul_p[48:0];
                        state_reg <= S_SM2;
                    end
                end
                S_SM2:
                begin
                    if (mul_done)
                    begin
                        curve_reg <= mul_p[48:32];
                        state_reg <= S_WGT;
                    end
                end
                S_BMID:
                begin
                    // After the last bisection step the y curve is evaluated
                    // at the last midpoint.
                    if (step_reg == STEP_W'(EASE_STEPS))
                    begin
                        pass_y_reg <= 1'b1;
                    end
                    else
                    begin
                        s_reg <= mid_sum[17:1];
                    end
                    state_reg <= S_C1;
                end
                S_C1:
                begin
                    if (mul_done)
                    begin
                        us_reg    <= mul_p[32:0];
                        state_reg <= S_C2;
                    end
                end
                S_C2:
                begin
                    if (mul_done)
                    begin
                        tmp_reg   <= mul_p[48:0];
                        state_reg <= S_C3;
                    end
                end
                S_C3:
                begin
                    if (mul_done)
                    begin
                        w1_reg    <= mul_p[48:16];
                        state_reg <= S_C4;
                    end
                end
                S_C4:
                begin
                    if (mul_done)
                    begin
                        tmp_reg   <= mul_p[48:0];
                        state_reg <= S_C5;
                    end
                end
                S_C5:
                begin
                    if (mul_done)
                    begin
                        w2_reg    <= mul_p[48:16];
                        state_reg <= S_C6;
                    end
                end
                S_C6:
                begin
                    if (mul_done)
                    begin
                        tmp_reg   <= mul_p[48:0];
                        state_reg <= S_C7;
                    end
                end
                S_C7:
                begin
                    if (mul_done)
                    begin
                        w3_reg    <= mul_p[48:16];
                        state_reg <= S_C8;
                    end
                end
                S_C8:
                begin
                    if (mul_done)
                    begin
                        acc1_reg  <= mul_p[48:0];
                        state_reg <= S_C9;
                    end
                end
                S_C9:
                begin
                    if (mul_done)
                    begin
                        val_reg   <= bez_sum[49:32];
                        state_reg <= S_BCMP;
                    end
                end
                S_BCMP:
                begin
                    if (pass_y_reg)
                    begin
                        curve_reg <= (val_reg > {1'b0, ONE_Q16}) ? ONE_Q16 : val_reg[16:0];
                        state_reg <= S_WGT;
                    end
                    else
                    begin
                        if (val_reg < {1'b0, a_reg})
                        begin
                            lo_reg <= s_reg;
                        end
                        else
                        begin
                            hi_reg <= s_reg;
                        end
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= S_BMID;
                    end
                end
                S_WGT:
                begin
                    if (mul_done)
                    begin
                        level_reg <= mul_p[24:8];
                        k_reg     <= '0;
                        if (mul_p[24:8] > APPLY_MIN)
                        begin
                            active_reg <= 1'b1;
                            state_reg  <= S_O1;
                        end
                        else
                        begin
                            state_reg <= S_END;
                        end
                    end
                end
                S_O1:
                begin
                    if (mul_done)
                    begin
                        fk_reg    <= mul_p[32:0];
                        state_reg <= S_O2;
                    end
                end
                S_O2:
                begin
                    if (mul_done)
                    begin
                        xo_reg    <= {fold, 2'b00};
                        neg_reg   <= ph[15];
                        state_reg <= S_O3;
                    end
                end
                S_O3:
                begin
                    if (mul_done)
                    begin
                        x2_reg    <= mul_p[32:16];
                        state_reg <= S_O4;
                    end
                end
                S_O4:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= SIN_B - mul_p[32:16];
                        state_reg <= S_O5;
                    end
                end
                S_O5:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= sin_t[16:0];
                        state_reg <= S_O6;
                    end
                end
                S_O6:
                begin
                    if (mul_done)
                    begin
                        mag_reg   <= (mul_p[33:16] > {1'b0, ONE_Q16}) ? ONE_Q16
                                                                      : mul_p[32:16];
                        state_reg <= S_O7;
                    end
                end
                S_O7:
                begin
                    if (mul_done)
                    begin
                        ma_reg    <= mul_p[32:0];
                        state_reg <= S_O8;
                    end
                end
                S_O8:
                begin
                    if (mul_done)
                    begin
                        off_reg[k_reg] <= neg_reg ? (17'd0 - v_w) : v_w;
                        k_reg          <= k_reg + 2'd1;
                        state_reg      <= (k_reg == 2'd3) ? S_END : S_O1;
                    end
                end
                S_END:
                begin
                    if ((cfg.duration != 32'd0) && (elapsed_reg >= cfg.duration)
                        && (level_reg <= END_MAX))
                    begin
                        enabled_reg <= 1'b0;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.active          = active_reg;
        res.offset_x        = off_reg[0];
        res.offset_y        = off_reg[1];
        res.offset_z        = off_reg[2];
        res.rotation_offset = off_reg[3];
        res.envelope        = level_reg;
        res.running         = enabled_reg;
    end

endmodule

[design/shake_envelope_oscillator.sv]
// ----------------------------------------------------------------------------
// shake_envelope_oscillator: camera-shake envelope and sine oscillators
// Keeps the shake time, forms a weighted easing envelope and drives four
// sine oscillators that give three location offsets and one rotation offset.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                     | Content
//  ---------+-----------------------------+-----------------------------------
//  s_*      | s_tvalid s_tready s_tuser   | tuser: op (0 start, 1 tick)
//           | s_tdata[15:0]               | tdata: delta_time
//  m_*      | m_tvalid m_tready m_tdata   | tdata: active, offset_x, offset_y,
//           |                             | offset_z, rotation_offset,
//           |                             | envelope, running (low bit first)
//  cfg_*    | cfg_we cfg_index cfg_data   | register writes, no read-back
//
// A start item goes straight to its result; a tick on a disabled block only runs
// the end check. A smoothstep tick with output applied, and the Bezier curve
// with its EASE_STEPS + 1 cubic evaluations, spend most of their time in the
// one shift-add multiplier, which
// retires one multiplier bit per cycle and serves every product.
// Reset brings the registers to their defaults and the block is ready at
// once. The input is refused while an item is in work; a finished transfer
// waits in the output register, so a stalled consumer holds up the next item
// only once its result is also done.
//
module shake_envelope_oscillator
    import sev_pkg::*;
#(
    parameter int EASE_STEPS = EASE_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [0:0]            s_tuser,   // [0] op
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] delta_time
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] active, [17:1] offset_x, [34:18] offset_y, [51:35] offset_z,
    // [68:52] rotation_offset, [85:69] envelope, [86] running, [87] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                  cfg_reg;
    logic                  core_idle;
    logic                  core_start;
    logic                  res_valid;
    logic                  res_ready;
    res_t                  res;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Configuration registers. The weight saturates at one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{weight: WEIGHT_ONE, default: '0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DURATION:
                begin
                    cfg_reg.duration <= cfg_data[31:0];
                end
                REG_BLEND:
                begin
                    cfg_reg.blend_in  <= cfg_data[15:0];
                    cfg_reg.blend_out <= cfg_data[31:16];
                end
                REG_FREQUENCY:
                begin
                    cfg_reg.frequency <= cfg_data[15:0];
                end
                REG_AMPLITUDES:
                begin
                    cfg_reg.amp_loc <= cfg_data[15:0];
                    cfg_reg.amp_rot <= cfg_data[31:16];
                end
                REG_WEIGHT:
                begin
                    cfg_reg.weight <= (cfg_data[8:0] > WEIGHT_ONE) ? WEIGHT_ONE
                                                                   : cfg_data[8:0];
                end
                REG_CURVE_MODE:
                begin
                    cfg_reg.curve_mode <= cfg_data[0];
                end
                REG_BEZIER:
                begin
                    cfg_reg.p1x <= cfg_data[15:0];
                    cfg_reg.p1y <= cfg_data[31:16];
                    cfg_reg.p2x <= cfg_data[47:32];
                    cfg_reg.p2y <= cfg_data[63:48];
                end
                REG_PHASES:
                begin
                    cfg_reg.phase <= cfg_data;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // One item is in work at a time; the core takes it from its idle state.
    assign s_tready   = core_idle;
    assign core_start = s_tvalid && core_idle;

    sev_core #(
        .EASE_STEPS (EASE_STEPS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .start      (core_start),
        .op         (s_tuser[0]),
        .delta_time (s_tdata),
        .idle       (core_idle),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: loads whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_tdata_reg <= {1'b0, res.running, res.envelope, res.rotation_offset,
                            res.offset_z, res.offset_y, res.offset_x, res.active};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[design/sev_checker.sv]
// ----------------------------------------------------------------------------
// sev_checker: port-level checks of the shake envelope oscillator
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module sev_checker
    import sev_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An item in work blocks the input for at least the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // Offsets are only applied above the weak-envelope level.
    a_active_env: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[85:69] > APPLY_MIN))
        else $error("active with weak envelope");

    // Inactive results carry zero offsets.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[68:1] == 68'd0))
        else $error("offsets set while inactive");

    // The envelope never exceeds one.
    a_env_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[85:69] <= ONE_Q16))
        else $error("envelope above one");

endmodule

bind shake_envelope_oscillator sev_checker u_sev_checker (.*);
